/* sv/jhss_pkg.sv */
// Shared types and codes for the JPEG header size sniffer.
package jhss_pkg;

	localparam logic [2:0] PH_SOI     = 3'd0;
	localparam logic [2:0] PH_LEN_HI  = 3'd1;
	localparam logic [2:0] PH_LEN_LO  = 3'd2;
	localparam logic [2:0] PH_SKIP    = 3'd3;
	localparam logic [2:0] PH_MARK_FF = 3'd4;
	localparam logic [2:0] PH_MARK_ID = 3'd5;
	localparam logic [2:0] PH_FRAME   = 3'd6;
	localparam logic [2:0] PH_WAIT    = 3'd7;

	localparam logic [1:0] ST_FOUND   = 2'd0;
	localparam logic [1:0] ST_BAD_SOI = 2'd1;
	localparam logic [1:0] ST_BAD_MRK = 2'd2;
	localparam logic [1:0] ST_RUNOUT  = 2'd3;

	localparam logic [7:0] BYTE_FF  = 8'hFF;
	localparam logic [7:0] BYTE_SOI = 8'hD8;
	localparam logic [7:0] SOF_LO   = 8'hC0;
	localparam logic [7:0] SOF_HI   = 8'hC2;

	localparam logic [7:0] UNITS_INCH = 8'd1;
	localparam logic [7:0] UNITS_CM   = 8'd2;
	localparam logic [7:0] CENTI_INCH = 8'd100;
	localparam logic [7:0] CENTI_CM   = 8'd254;

	localparam logic [15:0] FALLBACK_RST = 16'd300;
	localparam logic [4:0]  OFF_SAT      = 5'd18;

	// Raw result as produced by the parser, before density scaling.
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] width;
		logic [15:0] height;
		logic [7:0]  comps;
		logic [7:0]  units;
		logic [15:0] x_den;
		logic [15:0] y_den;
	} raw_res_t;

endpackage

/* sv/jhss_parse.sv */
// Byte-wise header parser with the raw result register.
module jhss_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	input  logic               res_take,
	output logic               res_valid_s1,
	output jhss_pkg::raw_res_t res_s1
);
	import jhss_pkg::*;

	logic [2:0]  phase_q, phase_u;
	logic [4:0]  off_q, off_u;
	logic [15:0] skip_q, skip_u;
	logic [7:0]  lenhi_q, lenhi_u;
	logic [7:0]  units_q, units_u;
	logic [15:0] xden_q, xden_u;
	logic [15:0] yden_q, yden_u;
	logic [15:0] fh_q, fh_u;
	logic [15:0] fw_q, fw_u;
	logic [7:0]  fc_q, fc_u;
	logic        cap_q, cap_u;
	logic        sent_q, sent_u;
	logic        hit;
	logic [1:0]  code;
	logic        emit;
	logic        clear;
	logic [15:0] len;

	always_comb begin
		phase_u = phase_q;
		off_u   = off_q;
		skip_u  = skip_q;
		lenhi_u = lenhi_q;
		units_u = units_q;
		xden_u  = xden_q;
		yden_u  = yden_q;
		fh_u    = fh_q;
		fw_u    = fw_q;
		fc_u    = fc_q;
		cap_u   = cap_q;
		sent_u  = sent_q;
		hit     = 1'b0;
		code    = ST_FOUND;
		len     = {lenhi_q, data_byte};

		// fixed-offset density fields
		unique case (off_q)
			5'd13: units_u = data_byte;
			5'd14: xden_u = {data_byte, 8'd0};
			5'd15: xden_u = {xden_q[15:8], data_byte};
			5'd16: yden_u = {data_byte, 8'd0};
			5'd17: yden_u = {yden_q[15:8], data_byte};
			default: ;
		endcase

		unique case (phase_q)
			PH_SOI: begin
				if ((off_q == 5'd0 && data_byte != BYTE_FF) ||
				    (off_q == 5'd1 && data_byte != BYTE_SOI) ||
				    (off_q == 5'd2 && data_byte != BYTE_FF)) begin
					hit  = 1'b1;
					code = ST_BAD_SOI;
				end else if (off_q >= 5'd3) begin
					phase_u = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				lenhi_u = data_byte;
				phase_u = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				if (len < 16'd2) begin
					hit  = 1'b1;
					code = ST_BAD_MRK;
				end else begin
					skip_u  = len - 16'd2;
					phase_u = (len != 16'd2) ? PH_SKIP : PH_MARK_FF;
				end
			end
			PH_SKIP: begin
				skip_u = skip_q - 16'd1;
				if (skip_q == 16'd1) phase_u = PH_MARK_FF;
			end
			PH_MARK_FF: begin
				if (data_byte != BYTE_FF) begin
					hit  = 1'b1;
					code = ST_BAD_MRK;
				end else begin
					phase_u = PH_MARK_ID;
				end
			end
			PH_MARK_ID: begin
				if (data_byte >= SOF_LO && data_byte <= SOF_HI) begin
					phase_u = PH_FRAME;
					skip_u  = 16'd0;
				end else begin
					phase_u = PH_LEN_HI;
				end
			end
			PH_FRAME: begin
				// length(2), precision(1), height(2), width(2), components(1)
				unique case (skip_q)
					16'd3: fh_u = {data_byte, 8'd0};
					16'd4: fh_u = {fh_q[15:8], data_byte};
					16'd5: fw_u = {data_byte, 8'd0};
					16'd6: fw_u = {fw_q[15:8], data_byte};
					16'd7: begin
						fc_u    = data_byte;
						cap_u   = 1'b1;
						phase_u = PH_WAIT;
					end
					default: ;
				endcase
				skip_u = skip_q + 16'd1;
			end
			default: ;
		endcase

		if (!hit && cap_u && off_q >= 5'd17) begin
			hit  = 1'b1;
			code = ST_FOUND;
		end
		if (off_q < OFF_SAT) off_u = off_q + 5'd1;
		if (!hit && last_byte) begin
			hit  = 1'b1;
			code = ST_RUNOUT;
		end

		emit  = hit && !sent_q;
		clear = last_byte;
		if (emit) sent_u = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SOI;
			off_q   <= '0;
			skip_q  <= '0;
			lenhi_q <= '0;
			units_q <= '0;
			xden_q  <= '0;
			yden_q  <= '0;
			fh_q    <= '0;
			fw_q    <= '0;
			fc_q    <= '0;
			cap_q   <= 1'b0;
			sent_q  <= 1'b0;
		end else if (in_fire) begin
			if (clear) begin
				// end of file: start over for the next one
				phase_q <= PH_SOI;
				off_q   <= '0;
				skip_q  <= '0;
				lenhi_q <= '0;
				units_q <= '0;
				xden_q  <= '0;
				yden_q  <= '0;
				fh_q    <= '0;
				fw_q    <= '0;
				fc_q    <= '0;
				cap_q   <= 1'b0;
				sent_q  <= 1'b0;
			end else if (!sent_q) begin
				phase_q <= phase_u;
				off_q   <= off_u;
				skip_q  <= skip_u;
				lenhi_q <= lenhi_u;
				units_q <= units_u;
				xden_q  <= xden_u;
				yden_q  <= yden_u;
				fh_q    <= fh_u;
				fw_q    <= fw_u;
				fc_q    <= fc_u;
				cap_q   <= cap_u;
				sent_q  <= sent_u;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (in_fire && emit) begin
			res_valid_s1 <= 1'b1;
		end else if (res_take) begin
			res_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			res_s1.status <= code;
			res_s1.width  <= fw_u;
			res_s1.height <= fh_u;
			res_s1.comps  <= fc_u;
			res_s1.units  <= units_u;
			res_s1.x_den  <= xden_u;
			res_s1.y_den  <= yden_u;
		end
	end

endmodule

/* sv/jhss_scale.sv */
// Density scaling to centi-dpi and the output register.
module jhss_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid_s1,
	input  jhss_pkg::raw_res_t res_s1,
	input  logic [15:0]        fallback,
	output logic               res_take,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [1:0]         status,
	output logic [15:0]        image_width,
	output logic [15:0]        image_height,
	output logic [7:0]         components,
	output logic [23:0]        dpi_x_centi,
	output logic [23:0]        dpi_y_centi
);
	import jhss_pkg::*;

	logic        known;
	logic        ok;
	logic [7:0]  factor;
	logic [15:0] x_src, y_src;
	logic [23:0] x_prod, y_prod;
	logic        s2_ready;

	always_comb begin
		known  = (res_s1.units == UNITS_INCH) || (res_s1.units == UNITS_CM);
		ok     = (res_s1.status == ST_FOUND);
		factor = (res_s1.units == UNITS_CM) ? CENTI_CM : CENTI_INCH;
		x_src  = known ? res_s1.x_den : fallback;
		y_src  = known ? res_s1.y_den : fallback;
		// widen before the multiply so the full product survives
		x_prod = 24'(x_src) * 24'(factor);
		y_prod = 24'(y_src) * 24'(factor);
	end

	assign s2_ready = !out_valid || !out_stall;
	assign res_take = res_valid_s1 && s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s2_ready) begin
			out_valid <= res_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			status       <= res_s1.status;
			image_width  <= ok ? res_s1.width : '0;
			image_height <= ok ? res_s1.height : '0;
			components   <= ok ? res_s1.comps : '0;
			dpi_x_centi  <= ok ? x_prod : '0;
			dpi_y_centi  <= ok ? y_prod : '0;
		end
	end

endmodule

/* sv/jpeg_header_size_sniffer_top.sv */
// Top level of the JPEG header size sniffer.
// Usage:
//   Input channel: one file byte per beat on data_byte, with last_byte set on
//   the final byte of the file. A beat moves when in_valid is high and
//   in_stall is low. Every accepted byte is consumed as it moves, so a file streams
//   at one byte per cycle while the output side keeps up.
//   Output channel: one result beat per file (status, frame size, component
//   count, densities in centi-dpi), moved when out_valid is high and
//   out_stall is low. Fields other than status are zero on an error status.
//   Result path: once the byte that decides it is accepted, the result is
//   registered in the parser register, then in the density multiply register.
//   Bytes after the deciding one are swallowed up to and including the last
//   byte, which rearms the parser for the next file.
//   Stall: a held result waits in the output register while the parser
//   register can hold one more; in_stall rises only when both are full.
//   Config: fallback_dpi is written through cfg_valid/cfg_ready (always
//   ready); write it only while no file is in flight. Reset value is 300.
//   Reset: arst_n clears the parser state, both valid flags and sets the
//   fallback register to 300.
module jpeg_header_size_sniffer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic [7:0]  components,
	output logic [23:0] dpi_x_centi,
	output logic [23:0] dpi_y_centi,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] fallback_dpi
);
	import jhss_pkg::*;

	logic        in_fire;
	logic        res_valid_s1;
	raw_res_t    res_s1;
	logic        res_take;
	logic [15:0] fallback_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = res_valid_s1 && !res_take;
	assign in_fire   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fallback_q <= FALLBACK_RST;
		end else if (cfg_valid && cfg_ready) begin
			fallback_q <= fallback_dpi;
		end
	end

	jhss_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_fire      (in_fire),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.res_take     (res_take),
		.res_valid_s1 (res_valid_s1),
		.res_s1       (res_s1)
	);

	jhss_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid_s1 (res_valid_s1),
		.res_s1       (res_s1),
		.fallback     (fallback_q),
		.res_take     (res_take),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.status       (status),
		.image_width  (image_width),
		.image_height (image_height),
		.components   (components),
		.dpi_x_centi  (dpi_x_centi),
		.dpi_y_centi  (dpi_y_centi)
	);

endmodule

/* sv/jhss_check.sv */
// Port-level checker for the JPEG header size sniffer, bound to the top level.
module jhss_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [15:0] image_width,
	input logic [15:0] image_height,
	input logic [7:0]  components,
	input logic [23:0] dpi_x_centi,
	input logic [23:0] dpi_y_centi
);
	import jhss_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(image_width) &&
			$stable(dpi_x_centi))
		else $error("stalled result changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_FOUND |-> image_width == 16'd0 &&
			image_height == 16'd0 && components == 8'd0 &&
			dpi_x_centi == 24'd0 && dpi_y_centi == 24'd0)
		else $error("error result carries nonzero fields");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without a byte two cycles earlier");

endmodule

bind jpeg_header_size_sniffer_top jhss_check u_jhss_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.image_width  (image_width),
	.image_height (image_height),
	.components   (components),
	.dpi_x_centi  (dpi_x_centi),
	.dpi_y_centi  (dpi_y_centi)
);
